[rtl/qslerp_pkg.sv]
// ---------------------------------------------------------------------------
// qslerp_pkg
// Shared types, constants and the sine polynomial for the slerp pipeline.
// ---------------------------------------------------------------------------
package qslerp_pkg;

   // Width of angles, cosines and sines in Q0.30 (one extra bit holds 1.0).
   localparam int AW = 31;
   // Width of a component and of the blend factor.
   localparam int CW = 16;
   // Number of quaternion components.
   localparam int NCOMP = 4;
   // Number of bit steps of the arccos search (bit 29 down to bit 0).
   localparam int ACOS_STEPS = 30;
   // Stages of one sine evaluation: square, four Horner steps, final product.
   localparam int SINQ_LAT = 6;
   localparam int HORNER = SINQ_LAT - 2;
   // Quotient bits produced by the weight divider.
   localparam int QW = 32;

   localparam logic [AW-1:0] ONE30 = 31'h4000_0000;
   localparam logic [QW-1:0] W_MAX = 32'h8000_0000;
   localparam logic [CW-1:0] BLEND_ONE = 16'h8000;

   // Taylor coefficients of sin(pi/2 * z) in Q30, lowest order first.
   localparam logic [AW-1:0] C1 = 31'd1686629713;
   localparam logic [AW-1:0] C3 = 31'd693598668;
   localparam logic [AW-1:0] C5 = 31'd85569306;
   localparam logic [AW-1:0] C7 = 31'd5026995;
   localparam logic [AW-1:0] C9 = 31'd172272;

   // Coefficient used by Horner step k (step 0 is the seed value).
   function automatic logic [AW-1:0] sin_coef(input int k);
      logic [AW-1:0] r;
      unique case (k)
         0: r = C9;
         1: r = C7;
         2: r = C5;
         3: r = C3;
         default: r = C1;
      endcase
      return r;
   endfunction

   // Per-item data that rides along the pipeline.
   typedef struct packed {
      logic                       czero;  // cosine is exactly zero
      logic                       slerp;  // angle is large enough for slerp
      logic [CW-1:0]              t;      // saturated blend factor
      logic [NCOMP-1:0][CW:0]     bn;     // second quaternion, sign fixed
      logic [NCOMP-1:0][CW-1:0]   a;      // first quaternion
   } item_type;

endpackage

[rtl/quaternion_slerp_unit.sv]
// ---------------------------------------------------------------------------
// quaternion_slerp_unit
// Spherical linear interpolation of two Q1.15 unit quaternions.
// ---------------------------------------------------------------------------
// Throughput: one item per cycle while the output is not held; the 30-step
// arccos search and the weight divider are fully pipelined.
// A held result stalls the whole pipeline in place until it is taken.
// Reset clears all valid bits and loads the threshold register with 33.
// ---------------------------------------------------------------------------
module quaternion_slerp_unit import qslerp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wen,
   input  logic [15:0]  csr_wdata,   // small_angle_threshold
   input  logic         req_tvalid,
   output logic         req_tready,
   // a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, blend
   input  logic [143:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // out_x, out_y, out_z, out_w
   output logic [63:0]  rsp_tdata
);

   localparam int IW = $bits(item_type);
   localparam int PW = 50;
   localparam int SW = 52;

   logic            en;
   logic [CW-1:0]   thr_ff;

   // Stage registers ahead of the arccos search.
   logic                            d1_v_ff, d2_v_ff, d3_v_ff;
   logic signed [31:0]              prod_ff [NCOMP];
   logic [NCOMP-1:0][CW-1:0]        a1_ff, a2_ff, b1_ff, b2_ff;
   logic [CW-1:0]                   t1_ff, t2_ff;
   logic signed [33:0]              dot_ff;
   logic signed [33:0]              mag;
   logic [AW-1:0]                   c_in;
   item_type                        item_in;
   item_type                        d3_item_ff;
   logic [AW-1:0]                   c_ff;

   // Arccos chain.
   logic            ac_v  [ACOS_STEPS+1];
   logic [AW-1:0]   ac_w  [ACOS_STEPS+1];
   logic [AW-1:0]   ac_c  [ACOS_STEPS+1];
   logic [IW-1:0]   ac_sb [ACOS_STEPS+1];

   // Angle scaling.
   item_type        ac_item;
   logic [AW-1:0]   wfin;
   logic [46:0]     tw_p, uw_p;
   logic            m_v_ff;
   logic [AW-1:0]   w_ff, tw_ff, uw_ff;
   item_type        m_item_ff;

   // Sines and weights.
   logic                    sn_v;
   logic [2:0][AW-1:0]      sn_z, sn_r;
   logic [IW-1:0]           sn_sb;
   logic                    dv_v;
   logic [1:0][QW-1:0]      dv_q;
   logic [1:0]              dv_ovf;
   logic [IW:0]             dv_sb;
   logic                    swz;
   item_type                dv_item;
   logic                    linear;
   logic [QW-1:0]           lin0, lin1, sl0, sl1;
   logic                    sel_v_ff;
   logic [QW-1:0]           s0_ff, s1_ff;
   item_type                sel_item_ff;

   // Products and output.
   logic                    p_v_ff;
   logic signed [PW-1:0]    pa_ff [NCOMP];
   logic signed [PW-1:0]    pb_ff [NCOMP];
   logic                    rsp_tvalid_ff;
   logic [63:0]             rsp_tdata_ff;
   logic [63:0]             rsp_tdata_in;

   // The pipeline moves whenever the output register can take a result.
   assign en         = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = en;

   // Threshold register.
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= 16'd33;
      end else if (csr_wen) begin
         thr_ff <= csr_wdata;
      end
   end

   // Valid bits of the front stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         d1_v_ff <= 1'b0;
         d2_v_ff <= 1'b0;
         d3_v_ff <= 1'b0;
      end else if (en) begin
         d1_v_ff <= req_tvalid;
         d2_v_ff <= d1_v_ff;
         d3_v_ff <= d2_v_ff;
      end
   end

   // Stage one: component products and blend saturation.
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < NCOMP; i++) begin
            a1_ff[i]   <= req_tdata[CW*i +: CW];
            b1_ff[i]   <= req_tdata[CW*(NCOMP+i) +: CW];
            prod_ff[i] <= 32'($signed(req_tdata[CW*i +: CW]))
                        * 32'($signed(req_tdata[CW*(NCOMP+i) +: CW]));
         end
         t1_ff <= (req_tdata[CW*2*NCOMP +: CW] > BLEND_ONE) ?
                  BLEND_ONE : req_tdata[CW*2*NCOMP +: CW];
      end
   end

   // Stage two: dot product.
   always_ff @(posedge clock) begin
      if (en) begin
         dot_ff <= 34'(prod_ff[0]) + 34'(prod_ff[1]) + 34'(prod_ff[2]) + 34'(prod_ff[3]);
         a2_ff  <= a1_ff;
         b2_ff  <= b1_ff;
         t2_ff  <= t1_ff;
      end
   end

   // Stage three: short-arc fix, cosine clamp and threshold test.
   always_comb begin
      mag          = dot_ff[33] ? -dot_ff : dot_ff;
      c_in         = (mag > 34'(ONE30)) ? ONE30 : mag[AW-1:0];
      item_in.a    = a2_ff;
      item_in.t    = t2_ff;
      item_in.czero = (c_in == '0);
      item_in.slerp = (ONE30 - c_in) > {thr_ff, 15'b0};
      for (int i = 0; i < NCOMP; i++) begin
         item_in.bn[i] = dot_ff[33] ? 17'(-17'($signed(b2_ff[i])))
                                    : 17'($signed(b2_ff[i]));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d3_item_ff <= item_in;
         c_ff       <= c_in;
      end
   end

   // Arccos: one angle bit per step, from bit 29 down.
   assign ac_v[0]  = d3_v_ff;
   assign ac_w[0]  = '0;
   assign ac_c[0]  = c_ff;
   assign ac_sb[0] = d3_item_ff;

   for (genvar k = 0; k < ACOS_STEPS; k++) begin : g_acos
      qslerp_acos_step #(.BIT(ACOS_STEPS-1-k), .SB_W(IW)) u_step (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (ac_v[k]),
         .in_w      (ac_w[k]),
         .in_c      (ac_c[k]),
         .in_sb     (ac_sb[k]),
         .out_valid (ac_v[k+1]),
         .out_w     (ac_w[k+1]),
         .out_c     (ac_c[k+1]),
         .out_sb    (ac_sb[k+1])
      );
   end

   // A zero cosine gives a full quarter turn; then scale the angle by t and by one minus t.
   assign ac_item = item_type'(ac_sb[ACOS_STEPS]);
   assign wfin    = ac_item.czero ? ONE30 : ac_w[ACOS_STEPS];
   assign tw_p    = 47'(ac_item.t) * 47'(wfin);
   assign uw_p    = 47'(BLEND_ONE - ac_item.t) * 47'(wfin);

   always_ff @(posedge clock) begin
      if (reset) begin
         m_v_ff <= 1'b0;
      end else if (en) begin
         m_v_ff <= ac_v[ACOS_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         w_ff      <= wfin;
         tw_ff     <= AW'(tw_p >> 15);
         uw_ff     <= AW'(uw_p >> 15);
         m_item_ff <= ac_item;
      end
   end

   // Sines of the angle and of both scaled angles.
   assign sn_z = {tw_ff, uw_ff, w_ff};

   qslerp_sinq #(.LANES(3), .SB_W(IW)) u_sin (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (m_v_ff),
      .in_z      (sn_z),
      .in_sb     (m_item_ff),
      .out_valid (sn_v),
      .out_r     (sn_r),
      .out_sb    (sn_sb)
   );

   // Sine ratios for both weights.
   qslerp_div #(.LANES(2), .SB_W(IW+1)) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sn_v),
      .in_num    ({sn_r[2], sn_r[1]}),
      .in_den    (sn_r[0]),
      .in_sb     ({sn_r[0] == '0, sn_sb}),
      .out_valid (dv_v),
      .out_q     (dv_q),
      .out_ovf   (dv_ovf),
      .out_sb    (dv_sb)
   );

   // Weight selection: slerp ratios or linear weights.
   assign swz     = dv_sb[IW];
   assign dv_item = item_type'(dv_sb[IW-1:0]);
   assign linear  = !dv_item.slerp || swz;
   assign lin0    = QW'({BLEND_ONE - dv_item.t, 15'b0});
   assign lin1    = QW'({dv_item.t, 15'b0});
   assign sl0     = (dv_ovf[0] || dv_q[0] > W_MAX) ? W_MAX : dv_q[0];
   assign sl1     = (dv_ovf[1] || dv_q[1] > W_MAX) ? W_MAX : dv_q[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_v_ff <= 1'b0;
         p_v_ff   <= 1'b0;
      end else if (en) begin
         sel_v_ff <= dv_v;
         p_v_ff   <= sel_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_ff       <= linear ? lin0 : sl0;
         s1_ff       <= linear ? lin1 : sl1;
         sel_item_ff <= dv_item;
      end
   end

   // Weighted components.
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < NCOMP; i++) begin
            pa_ff[i] <= PW'($signed({1'b0, s0_ff})) * PW'($signed(sel_item_ff.a[i]));
            pb_ff[i] <= PW'($signed({1'b0, s1_ff})) * PW'($signed(sel_item_ff.bn[i]));
         end
      end
   end

   // Sum, round half up, floor and saturate.
   always_comb begin
      logic signed [SW-1:0] acc;
      logic signed [SW-1:0] q;
      rsp_tdata_in = '0;
      for (int i = 0; i < NCOMP; i++) begin
         acc = SW'(pa_ff[i]) + SW'(pb_ff[i]) + 52'sh2000_0000;
         q   = acc >>> 30;
         if (q > 52'sd32767) begin
            rsp_tdata_in[CW*i +: CW] = 16'h7FFF;
         end else if (q < -52'sd32768) begin
            rsp_tdata_in[CW*i +: CW] = 16'h8000;
         end else begin
            rsp_tdata_in[CW*i +: CW] = q[CW-1:0];
         end
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (en) begin
         rsp_tvalid_ff <= p_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_tdata_ff <= rsp_tdata_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // The clamped cosine never exceeds one.
   a_cos_range: assert property (@(posedge clock) disable iff (reset)
      d3_v_ff |-> c_ff <= ONE30)
      else $error("cosine above one");

   // The slerp path is only chosen for a cosine strictly below one.
   a_slerp_cos: assert property (@(posedge clock) disable iff (reset)
      (d3_v_ff && d3_item_ff.slerp) |-> c_ff != ONE30)
      else $error("slerp chosen at unit cosine");

   // Selected weights stay within two.
   a_weight_range: assert property (@(posedge clock) disable iff (reset)
      sel_v_ff |-> (s0_ff <= W_MAX && s1_ff <= W_MAX))
      else $error("weight above two");

   // No result leaves the block straight after reset.
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

[rtl/qslerp_sinq.sv]
// ---------------------------------------------------------------------------
// qslerp_sinq
// Pipelined sine of a quarter-turn fraction, several lanes in lockstep.
// ---------------------------------------------------------------------------
module qslerp_sinq import qslerp_pkg::*; #(
   parameter int LANES = 1,
   parameter int SB_W  = 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_valid,
   input  logic [LANES-1:0][AW-1:0]   in_z,
   input  logic [SB_W-1:0]            in_sb,
   output logic                       out_valid,
   output logic [LANES-1:0][AW-1:0]   out_r,
   output logic [SB_W-1:0]            out_sb
);

   logic [SINQ_LAT-1:0] v_ff;
   logic [SB_W-1:0]     sb_ff [SINQ_LAT];

   // Valid bits travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[SINQ_LAT-2:0], in_valid};
      end
   end

   // Side data follows the same stages.
   always_ff @(posedge clock) begin
      if (en) begin
         sb_ff[0] <= in_sb;
         for (int s = 1; s < SINQ_LAT; s++) begin
            sb_ff[s] <= sb_ff[s-1];
         end
      end
   end

   for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [AW-1:0]   z_ff   [HORNER+1];
      logic [AW-1:0]   zsq_ff [HORNER+1];
      logic [AW-1:0]   p_ff   [HORNER+1];
      logic [AW-1:0]   r_ff;
      logic [AW-1:0]   zc;
      logic [2*AW-1:0] sq;
      logic [2*AW-1:0] hp [HORNER];
      logic [2*AW-1:0] fin;
      logic [2*AW-1:0] fin_sh;

      // Clamp the argument to one and square it.
      assign zc = (in_z[l] > ONE30) ? ONE30 : in_z[l];
      assign sq = (2*AW)'(zc) * (2*AW)'(zc);

      // One multiplier per Horner step.
      for (genvar s = 1; s <= HORNER; s++) begin : g_hp
         assign hp[s-1] = (2*AW)'(zsq_ff[s-1]) * (2*AW)'(p_ff[s-1]);
      end

      assign fin    = (2*AW)'(z_ff[HORNER]) * (2*AW)'(p_ff[HORNER]);
      assign fin_sh = fin >> 30;

      always_ff @(posedge clock) begin
         if (en) begin
            z_ff[0]   <= zc;
            zsq_ff[0] <= AW'(sq >> 30);
            p_ff[0]   <= sin_coef(0);
            for (int s = 1; s <= HORNER; s++) begin
               z_ff[s]   <= z_ff[s-1];
               zsq_ff[s] <= zsq_ff[s-1];
               p_ff[s]   <= sin_coef(s) - AW'(hp[s-1] >> 30);
            end
            r_ff <= (fin_sh > (2*AW)'(ONE30)) ? ONE30 : AW'(fin_sh);
         end
      end

      assign out_r[l] = r_ff;
   end

   assign out_valid = v_ff[SINQ_LAT-1];
   assign out_sb    = sb_ff[SINQ_LAT-1];

endmodule

[rtl/qslerp_acos_step.sv]
// ---------------------------------------------------------------------------
// qslerp_acos_step
// One bit of the arccos search: tries a bit of the angle and keeps it when
// the cosine of the candidate still reaches the target.
// ---------------------------------------------------------------------------
module qslerp_acos_step import qslerp_pkg::*; #(
   parameter int BIT  = 0,
   parameter int SB_W = 1
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            en,
   input  logic            in_valid,
   input  logic [AW-1:0]   in_w,
   input  logic [AW-1:0]   in_c,
   input  logic [SB_W-1:0] in_sb,
   output logic            out_valid,
   output logic [AW-1:0]   out_w,
   output logic [AW-1:0]   out_c,
   output logic [SB_W-1:0] out_sb
);

   localparam int XW = 3*AW + SB_W;

   logic [AW-1:0]   cand;
   logic [AW-1:0]   cz;
   logic [XW-1:0]   x_sb;
   logic            s_valid;
   logic [0:0][AW-1:0] s_r;
   logic [XW-1:0]   s_sb;
   logic [AW-1:0]   s_c;
   logic [AW-1:0]   s_cand;
   logic [AW-1:0]   s_w;
   logic [SB_W-1:0] s_rest;
   logic            v_ff;
   logic [AW-1:0]   w_ff;
   logic [AW-1:0]   c_ff;
   logic [SB_W-1:0] sb_ff;

   // Cosine of the candidate is the sine of its complement.
   assign cand = in_w | (AW'(1) << BIT);
   assign cz   = ONE30 - cand;
   assign x_sb = {in_c, cand, in_w, in_sb};

   qslerp_sinq #(.LANES(1), .SB_W(XW)) u_cos (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (in_valid),
      .in_z      (cz),
      .in_sb     (x_sb),
      .out_valid (s_valid),
      .out_r     (s_r),
      .out_sb    (s_sb)
   );

   assign {s_c, s_cand, s_w, s_rest} = s_sb;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (en) begin
         v_ff <= s_valid;
      end
   end

   // Keep the bit when the cosine stays at or above the target.
   always_ff @(posedge clock) begin
      if (en) begin
         w_ff  <= (s_r[0] >= s_c) ? s_cand : s_w;
         c_ff  <= s_c;
         sb_ff <= s_rest;
      end
   end

   assign out_valid = v_ff;
   assign out_w     = w_ff;
   assign out_c     = c_ff;
   assign out_sb    = sb_ff;

endmodule

[rtl/qslerp_div.sv]
// ---------------------------------------------------------------------------
// qslerp_div
// Pipelined restoring divider for (num << 30) / den, one quotient bit per
// stage, several numerators sharing one divisor.
// ---------------------------------------------------------------------------
module qslerp_div import qslerp_pkg::*; #(
   parameter int LANES = 1,
   parameter int SB_W  = 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_valid,
   input  logic [LANES-1:0][AW-1:0]  in_num,
   input  logic [AW-1:0]             in_den,
   input  logic [SB_W-1:0]           in_sb,
   output logic                      out_valid,
   output logic [LANES-1:0][QW-1:0]  out_q,
   output logic [LANES-1:0]          out_ovf,
   output logic [SB_W-1:0]           out_sb
);

   logic [QW:0]     v_ff;
   logic [SB_W-1:0] sb_ff  [QW+1];
   logic [AW-1:0]   den_ff [QW+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[QW-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sb_ff[0]  <= in_sb;
         den_ff[0] <= in_den;
         for (int k = 1; k <= QW; k++) begin
            sb_ff[k]  <= sb_ff[k-1];
            den_ff[k] <= den_ff[k-1];
         end
      end
   end

   for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [AW-1:0] rem_ff [QW+1];
      logic [QW-1:0] q_ff   [QW+1];
      logic [1:0]    nlo_ff [QW+1];
      logic [QW:0]   ovf_ff;

      // Entry: a quotient of 2^32 or more only ever clamps.
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[0] <= in_num[l] >> 2;
            nlo_ff[0] <= in_num[l][1:0];
            q_ff[0]   <= '0;
            ovf_ff[0] <= {2'b00, in_num[l]} >= {in_den, 2'b00};
         end
      end

      // One quotient bit per stage, most significant first.
      for (genvar k = 0; k < QW; k++) begin : g_bit
         localparam int QB = QW - 1 - k;
         logic          dbit;
         logic [AW:0]   trial;
         logic          ge;

         if (QB == QW - 1) begin : g_hi
            assign dbit = nlo_ff[k][1];
         end else if (QB == QW - 2) begin : g_lo
            assign dbit = nlo_ff[k][0];
         end else begin : g_zero
            assign dbit = 1'b0;
         end

         assign trial = {rem_ff[k], dbit};
         assign ge    = trial >= {1'b0, den_ff[k]};

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k+1] <= ge ? AW'(trial - {1'b0, den_ff[k]}) : AW'(trial);
               q_ff[k+1]   <= q_ff[k] | (QW'(ge) << QB);
               nlo_ff[k+1] <= nlo_ff[k];
               ovf_ff[k+1] <= ovf_ff[k];
            end
         end
      end

      assign out_q[l]   = q_ff[QW];
      assign out_ovf[l] = ovf_ff[QW];
   end

   assign out_valid = v_ff[QW];
   assign out_sb    = sb_ff[QW];

endmodule

[tb/tb_quaternion_slerp_unit.sv]
// ----------------------------------------------------------------------------
// tb_quaternion_slerp_unit
// Drives pairs of quaternions and blend factors into the slerp pipeline and
// checks every result against a fixed-point prediction of the interpolation.
// ----------------------------------------------------------------------------
module tb_quaternion_slerp_unit;
   timeunit 1ns;
   timeprecision 1ps;

   // Q30 constants of the predictor.
   localparam longint unsigned P_ONE = 64'd1 << 30;
   localparam longint unsigned P_WMAX = 64'd1 << 31;
   localparam int LATENCY = 256;
   localparam int WATCHDOG_LIMIT = 20000;

   // Q30 sine of a quarter-turn fraction, odd polynomial through z^9.
   function automatic longint unsigned sin_q30(longint unsigned z);
      longint unsigned z2, p, r;
      if (z > P_ONE) z = P_ONE;
      z2 = (z * z) >> 30;
      p = 64'd172272;
      p = 64'd5026995 - ((z2 * p) >> 30);
      p = 64'd85569306 - ((z2 * p) >> 30);
      p = 64'd693598668 - ((z2 * p) >> 30);
      p = 64'd1686629713 - ((z2 * p) >> 30);
      r = (z * p) >> 30;
      if (r > P_ONE) r = P_ONE;
      return r;
   endfunction

   function automatic longint unsigned cos_q30(longint unsigned z);
      if (z > P_ONE) z = P_ONE;
      return sin_q30(P_ONE - z);
   endfunction

   // Bitwise search for the largest angle whose cosine is still >= c.
   function automatic longint unsigned angle_of_cos(longint unsigned c);
      longint unsigned w, cand;
      w = 0;
      for (int k = 29; k >= 0; k--) begin
         cand = w | (64'd1 << k);
         if (cos_q30(cand) >= c) w = cand;
      end
      if (cos_q30(P_ONE) >= c) w = P_ONE;
      return w;
   endfunction

   function automatic longint unsigned weight_ratio(longint unsigned num,
                                                    longint unsigned den);
      longint unsigned q;
      q = (num << 30) / den;
      return (q > P_WMAX) ? P_WMAX : q;
   endfunction

   function automatic logic [15:0] mix_component(longint s0, longint s1,
                                                  longint a, longint b);
      longint v, q;
      v = s0 * a + s1 * b + (64'sd1 <<< 29);
      q = v >>> 30;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return q[15:0];
   endfunction

   // Expected interpolated quaternion for one packed input item.
   function automatic logic [63:0] slerp_predict(logic [143:0] d,
                                                 logic [15:0] thresh);
      longint a[4], b[4];
      longint dot;
      longint unsigned c, t, s0, s1, w, sw;
      logic [63:0] r;
      dot = 0;
      for (int k = 0; k < 4; k++) begin
         a[k] = longint'($signed(d[16*k +: 16]));
         b[k] = longint'($signed(d[64 + 16*k +: 16]));
         dot += a[k] * b[k];
      end
      if (dot < 0) begin
         dot = -dot;
         for (int k = 0; k < 4; k++) b[k] = -b[k];
      end
      c = dot;
      if (c > P_ONE) c = P_ONE;
      t = d[143:128];
      if (t > 32768) t = 32768;
      s0 = (32768 - t) << 15;
      s1 = t << 15;
      if ((P_ONE - c) > (longint'(thresh) << 15)) begin
         w = angle_of_cos(c);
         sw = sin_q30(w);
         if (sw != 0) begin
            s0 = weight_ratio(sin_q30(((32768 - t) * w) >> 15), sw);
            s1 = weight_ratio(sin_q30((t * w) >> 15), sw);
         end
      end
      for (int k = 0; k < 4; k++)
         r[16*k +: 16] = mix_component(s0, s1, a[k], b[k]);
      return r;
   endfunction

   // Holds the expected quaternions in order and compares results.
   class slerp_scoreboard;
      logic [63:0] pending_q[$];
      logic [15:0] thresh;
      int errors;
      int checked;

      function void note_item(logic [143:0] d);
         pending_q.push_back(slerp_predict(d, thresh));
      endfunction

      function void check_result(logic [63:0] got);
         logic [63:0] exp_v;
         if (pending_q.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
            return;
         end
         exp_v = pending_q.pop_front();
         checked++;
         for (int k = 0; k < 4; k++)
            if (exp_v[16*k +: 16] !== got[16*k +: 16]) begin
               $display("%0t: component %0d expected %0d actual %0d", $time, k,
                        $signed(exp_v[16*k +: 16]), $signed(got[16*k +: 16]));
               errors++;
            end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic csr_wen = 0;
   logic [15:0] csr_wdata = '0;
   logic req_tvalid = 0;
   logic req_tready;
   logic [143:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [63:0] rsp_tdata;

   slerp_scoreboard sb = new();
   int idle_pct_in = 25;
   int idle_pct_out = 25;
   bit hold_sink = 0;
   int watchdog = 0;

   always #5 clock = ~clock;

   quaternion_slerp_unit u_top (
      .clock(clock), .reset(reset), .csr_wen(csr_wen), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   // Result side: random stalls, checks at each accepted item.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
      rsp_tready <= !hold_sink && ($urandom_range(99) >= idle_pct_out);
   end

   // Watchdog on cycles with no handshake on either side.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) watchdog <= 0;
      else watchdog <= watchdog + 1;
      if (watchdog > WATCHDOG_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Valid stays high between back-to-back items; it drops only while idling.
   task automatic send_item(logic [143:0] d);
      while ($urandom_range(99) < idle_pct_in) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= d;
      do @(posedge clock); while (!req_tready);
      sb.note_item(d);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   task automatic write_thresh(logic [15:0] v);
      csr_wen <= 1;
      csr_wdata <= v;
      @(posedge clock);
      csr_wen <= 0;
      sb.thresh = v;
   endtask

   function automatic logic [15:0] rand_comp();
      case ($urandom_range(5))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   // Random item: mostly near-unit quaternions with b close to +/-a.
   function automatic logic [143:0] rand_item();
      logic [143:0] d;
      real n, v[8];
      int spread;
      if ($urandom_range(9) < 2) begin
         for (int k = 0; k < 8; k++) d[16*k +: 16] = rand_comp();
      end else begin
         n = 0;
         for (int k = 0; k < 4; k++) begin
            v[k] = real'($signed(16'($urandom))) + 1.0;
            n += v[k] * v[k];
         end
         n = $sqrt(n);
         spread = 1 << $urandom_range(15);
         for (int k = 0; k < 4; k++) begin
            v[k] = v[k] / n * 32760.0;
            d[16*k +: 16] = 16'($rtoi(v[k]));
            v[4+k] = v[k] + real'($signed(16'($urandom_range(2*spread) - spread)));
            if ($urandom_range(1)) v[4+k] = -v[4+k];
         end
         n = 0;
         for (int k = 4; k < 8; k++) n += v[k] * v[k];
         n = $sqrt(n) + 1.0;
         for (int k = 4; k < 8; k++) d[16*k +: 16] = 16'($rtoi(v[k] / n * 32760.0));
      end
      case ($urandom_range(7))
         0: d[143:128] = 16'h8000;
         1: d[143:128] = 16'($urandom);
         2: d[143:128] = 16'h0000;
         default: d[143:128] = 16'($urandom_range(32768));
      endcase
      return d;
   endfunction

   function automatic logic [143:0] pack(logic [15:0] ax, ay, az, aw,
                                         logic [15:0] bx, by, bz, bw, t);
      return {t, bw, bz, by, bx, aw, az, ay, ax};
   endfunction

   initial begin
      sb.thresh = 16'd33;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: identical, opposite, orthogonal, extremes, blend above one.
      send_item(pack(16'h0, 16'h0, 16'h0, 16'h7fff,
                     16'h0, 16'h0, 16'h0, 16'h7fff, 16'h4000));
      send_item(pack(16'h0, 16'h0, 16'h0, 16'h7fff,
                     16'h0, 16'h0, 16'h0, 16'h8001, 16'h4000));
      send_item(pack(16'h7fff, 16'h0, 16'h0, 16'h0,
                     16'h0, 16'h0, 16'h0, 16'h7fff, 16'h0000));
      send_item(pack(16'h7fff, 16'h0, 16'h0, 16'h0,
                     16'h0, 16'h0, 16'h0, 16'h7fff, 16'h8000));
      send_item(pack(16'h7fff, 16'h0, 16'h0, 16'h0,
                     16'h0, 16'h0, 16'h0, 16'h7fff, 16'h2000));
      send_item(pack(16'h7fff, 16'h0, 16'h0, 16'h0,
                     16'h0, 16'h0, 16'h0, 16'h8000, 16'h2000));
      send_item(pack(16'h0, 16'h0, 16'h0, 16'h7fff,
                     16'h8000, 16'h0, 16'h0, 16'h0001, 16'h6000));
      send_item(pack(16'h8000, 16'h8000, 16'h8000, 16'h8000,
                     16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'hffff));
      send_item(pack(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                     16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h9000));
      send_item(pack(16'h0, 16'h0, 16'h0, 16'h0,
                     16'h0, 16'h0, 16'h0, 16'h0, 16'h4000));
      send_item(pack(16'h5a82, 16'h0, 16'h0, 16'h5a82,
                     16'h0, 16'h0, 16'h0, 16'h7fff, 16'h4000));
      send_item(pack(16'h4000, 16'h4000, 16'h4000, 16'h4000,
                     16'h4001, 16'h3fff, 16'h4000, 16'h4000, 16'h1234));
      send_item(pack(16'h7fff, 16'h0, 16'h0, 16'h0,
                     16'h7ff0, 16'h0200, 16'h0, 16'h0, 16'h4000));
      drain();

      // Random phases across threshold settings, extremes included.
      for (int ph = 0; ph < 6; ph++) begin
         int n_items;
         case (ph)
            0: write_thresh(16'd0);
            1: write_thresh(16'd33);
            2: write_thresh(16'd32768);
            3: write_thresh(16'hffff);
            4: write_thresh(16'($urandom_range(4000)));
            default: write_thresh(16'd1);
         endcase
         idle_pct_in = (ph == 1) ? 0 : 25;
         idle_pct_out = (ph == 1) ? 0 : 25;
         // The stall phase sends enough items to keep offering once the
         // pipeline has filled and the input is held off.
         n_items = (ph == 2) ? 300 : 60;
         if (ph == 2) fork
            begin
               hold_sink = 1;
               repeat (LATENCY + 200) @(posedge clock);
               hold_sink = 0;
            end
         join_none
         for (int n = 0; n < n_items; n++) begin
            send_item(rand_item());
         end
         drain();
      end

      $display("Checked %0d results over six threshold settings, including a long",
               sb.checked);
      $display("output stall and full-rate bursts; %0d errors.", sb.errors);
      if (sb.errors == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end
endmodule

[files.f]
rtl/qslerp_pkg.sv
rtl/qslerp_sinq.sv
rtl/qslerp_acos_step.sv
rtl/qslerp_div.sv
rtl/quaternion_slerp_unit.sv
tb/tb_quaternion_slerp_unit.sv
